FILE: src/cspr_pkg.sv
package cspr_pkg;

	// Widths of the datapath.
	localparam int FREQ_W    = 32;
	localparam int MAIN_W    = 27;
	localparam int DIVISOR_W = 5;

	// The shared divider retires this many quotient bits per cycle.
	localparam int DIV_STEPS  = 4;
	localparam int DIV_CYCLES = FREQ_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	// Fixed oscillator frequencies.
	localparam logic [FREQ_W-1:0] OSC_HIGH_HZ = 32'd4000000;
	localparam logic [FREQ_W-1:0] OSC_LOW_HZ  = 32'd100000;
	localparam logic [MAIN_W-1:0] MAIN_RESET  = 27'd4000000;

	// Highest PLL feedback code that is accepted for a recompute.
	localparam logic [5:0] PLLN_LIMIT = 6'd49;

	// Register offsets.
	localparam logic [11:0] OFS_MODE     = 12'h000;
	localparam logic [11:0] OFS_STATUS   = 12'h004;
	localparam logic [11:0] OFS_PRESCALE = 12'h010;
	localparam logic [11:0] OFS_PLL_ONE  = 12'h038;
	localparam logic [11:0] OFS_PLL_TWO  = 12'h03c;

	// Bus command codes.
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Master clock select codes (mode bits 7:5).
	localparam logic [2:0] SEL_OSC_HIGH = 3'd0;
	localparam logic [2:0] SEL_MAIN     = 3'd1;
	localparam logic [2:0] SEL_PLL      = 3'd2;
	localparam logic [2:0] SEL_OSC_LOW  = 3'd4;
	localparam logic [2:0] SEL_MAIN_ALT = 3'd5;

	// Prescaler codes.
	localparam logic [2:0] PRE_DIV1  = 3'd0;
	localparam logic [2:0] PRE_DIV2  = 3'd1;
	localparam logic [2:0] PRE_DIV3  = 3'd2;
	localparam logic [2:0] PRE_DIV4  = 3'd3;
	localparam logic [2:0] PRE_DIV6  = 3'd4;
	localparam logic [2:0] PRE_DIV8  = 3'd5;
	localparam logic [2:0] PRE_DIV16 = 3'd6;

	typedef struct packed {
		logic                  go;
		logic [FREQ_W-1:0]     dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [FREQ_W-1:0] quotient;
	} div_rsp_t;

endpackage

FILE: src/clock_select_and_prescaler_regs.sv
// Clock select and prescaler register block.
//
// A bus request is presented on command, address and write_data and is taken
// at a rising edge where start is high and busy is low. Each request produces
// exactly one result: read_data together with the master and base clock
// frequencies as they stand after the access, shown for one cycle while done
// is high. The receiver cannot hold the result off, so it must take it then.
//
// A read, or a write that does not recompute the clocks, shows its result in
// the cycle straight after the request is taken; busy stays high until the
// result has been shown. A recompute with no division passes through the
// select and prescaler steps before done rises. Otherwise a small sequencer
// runs one shared divider, which retires four quotient bits a cycle, and
// waits in a divide step until the quotient is handed back. The PLL source,
// when enabled, costs one divide by K, and the divide-by-three and divide-by-six
// prescaler settings one more, so the longest write runs both divides. Busy
// stays high throughout, and the next request is taken once busy has fallen.
//
// The user must write the main clock frequency through main_clock_hz_wr only
// while idle; the block does not enforce this. Reset clears the mode, prescaler
// and PLL registers and sets the main clock register and both reported clocks to 4 MHz.
module clock_select_and_prescaler_regs
	import cspr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [11:0]       address,
	input  logic [31:0]       write_data,
	input  logic              main_clock_hz_wr,
	input  logic [MAIN_W-1:0] main_clock_hz,
	output logic              done,
	output logic [31:0]       read_data,
	output logic [31:0]       master_clock_hz,
	output logic [31:0]       base_clock_hz
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEL  = 3'd1;
	localparam logic [2:0] ST_DIVK = 3'd2;
	localparam logic [2:0] ST_PRE  = 3'd3;
	localparam logic [2:0] ST_DIVP = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	logic [2:0]        state_q;
	logic [MAIN_W-1:0] main_q;
	logic [7:0]        mode_q;
	logic [2:0]        prescale_q;
	logic [31:0]       pll_one_q;
	logic [5:0]        pll_two_q;
	logic [31:0]       master_q;
	logic [31:0]       base_q;
	logic [31:0]       rd_q;
	logic [31:0]       m_q;

	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic [38:0] pll_prod;
	logic [6:0]  pll_n;
	logic        wr_recompute;

	cspr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The PLL multiplier takes N = code + 1 and wraps the product to 32 bits.
	assign pll_n    = {1'b0, pll_two_q} + 7'd1;
	assign pll_prod = {7'd0, div_rsp.quotient} * {32'd0, pll_n};

	// A write to the mode, prescaler or PLL registers recomputes the clocks, except a
	// feedback code above the limit, which is kept but leaves the clocks as they are.
	always_comb begin
		wr_recompute = 1'b0;
		if (command == CMD_WRITE) begin
			case (address) inside
				OFS_MODE, OFS_PRESCALE, OFS_PLL_ONE: wr_recompute = 1'b1;
				OFS_PLL_TWO: wr_recompute = (write_data[5:0] <= PLLN_LIMIT);
				default:     wr_recompute = 1'b0;
			endcase
		end
	end

	// The divider is started for main/K in the select step when the PLL source is enabled, or for the
	// divide-by-three and divide-by-six prescaler codes in the prescaler step.
	always_comb begin
		div_req.go       = 1'b0;
		div_req.dividend = m_q;
		div_req.divisor  = 5'd3;
		if (state_q == ST_SEL) begin
			div_req.go       = (mode_q[7:5] == SEL_PLL) && mode_q[4];
			div_req.dividend = {{(32 - MAIN_W){1'b0}}, main_q};
			div_req.divisor  = {1'b0, pll_one_q[7:4]} + 5'd1;
		end else if (state_q == ST_PRE) begin
			div_req.go       = (prescale_q == PRE_DIV3) || (prescale_q == PRE_DIV6);
			div_req.dividend = m_q;
			div_req.divisor  = (prescale_q == PRE_DIV6) ? 5'd6 : 5'd3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			main_q     <= MAIN_RESET;
			mode_q     <= '0;
			prescale_q <= '0;
			pll_one_q  <= '0;
			pll_two_q  <= '0;
			master_q   <= OSC_HIGH_HZ;
			base_q     <= {{(32 - MAIN_W){1'b0}}, MAIN_RESET};
			m_q        <= '0;
		end else begin
			if (main_clock_hz_wr) begin
				main_q <= main_clock_hz;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= wr_recompute ? ST_SEL : ST_RESP;
						if (command == CMD_WRITE) begin
							// The register write lands first; the recompute then
							// works from the updated values.
							case (address)
								OFS_MODE:     mode_q     <= write_data[7:0];
								OFS_PRESCALE: prescale_q <= write_data[2:0];
								OFS_PLL_ONE:  pll_one_q  <= write_data;
								OFS_PLL_TWO:  pll_two_q  <= write_data[5:0];
								default: begin
								end
							endcase
						end
					end
				end
				ST_SEL: begin
					case (mode_q[7:5]) inside
						SEL_OSC_HIGH: begin
							m_q     <= OSC_HIGH_HZ;
							state_q <= ST_PRE;
						end
						SEL_MAIN, SEL_MAIN_ALT: begin
							m_q <= mode_q[3] ? {{(32 - MAIN_W){1'b0}}, main_q} : 32'd0;
							state_q <= ST_PRE;
						end
						SEL_PLL: begin
							if (mode_q[4]) begin
								state_q <= ST_DIVK;
							end else begin
								m_q     <= 32'd0;
								state_q <= ST_PRE;
							end
						end
						SEL_OSC_LOW: begin
							m_q     <= OSC_LOW_HZ;
							state_q <= ST_PRE;
						end
						// Reserved select codes leave both clocks untouched.
						default: state_q <= ST_RESP;
					endcase
				end
				ST_DIVK: begin
					if (div_rsp.done) begin
						m_q     <= pll_prod[31:0];
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					master_q <= m_q;
					state_q  <= ((prescale_q == PRE_DIV3) || (prescale_q == PRE_DIV6)) ?
						ST_DIVP : ST_RESP;
					case (prescale_q) inside
						PRE_DIV1:  base_q <= m_q;
						PRE_DIV2:  base_q <= {1'b0, m_q[31:1]};
						PRE_DIV4:  base_q <= {2'b0, m_q[31:2]};
						PRE_DIV8:  base_q <= {3'b0, m_q[31:3]};
						PRE_DIV16: base_q <= {4'b0, m_q[31:4]};
						// The divider delivers these two; the reserved code keeps
						// the old base clock.
						default: begin
						end
					endcase
				end
				ST_DIVP: begin
					if (div_rsp.done) begin
						base_q  <= div_rsp.quotient;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Read data is captured when the request is taken; writes return zero.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			if (command == CMD_READ) begin
				case (address) inside
					OFS_MODE, OFS_STATUS: rd_q <= {24'd0, mode_q};
					OFS_PRESCALE:         rd_q <= {29'd0, prescale_q};
					OFS_PLL_ONE:          rd_q <= pll_one_q;
					OFS_PLL_TWO:          rd_q <= {26'd0, pll_two_q};
					default:              rd_q <= 32'd0;
				endcase
			end else begin
				rd_q <= 32'd0;
			end
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign done            = (state_q == ST_RESP);
	assign read_data       = rd_q;
	assign master_clock_hz = master_q;
	assign base_clock_hz   = base_q;

endmodule

FILE: src/cspr_div.sv
// Restoring divider by a small divisor; DIV_STEPS quotient bits are retired per cycle.
module cspr_div
	import cspr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 running_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [FREQ_W-1:0]    work_q;

	logic [DIVISOR_W-1:0] rem_n;
	logic [FREQ_W-1:0]    work_n;
	logic [DIVISOR_W:0]   trial;

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	always_comb begin
		rem_n  = rem_q;
		work_n = work_q;
		trial  = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial  = {rem_n, work_n[FREQ_W-1]};
			work_n = {work_n[FREQ_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor_q}) begin
				trial     = trial - {1'b0, divisor_q};
				work_n[0] = 1'b1;
			end
			rem_n = trial[DIVISOR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= !req.go && running_q && (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));
			if (req.go) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			work_q    <= req.dividend;
			divisor_q <= req.divisor;
			rem_q     <= '0;
		end else if (running_q) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q;

endmodule
